FILE: design/vcw_pkg.sv
// ----------------------------------------------------------------------------
// vcw_pkg: shared types and constants for the Vegas congestion window block
// Request codes, register indexes, field widths and the divider command type.
// ----------------------------------------------------------------------------
package vcw_pkg;

  localparam int DW = 32;

  localparam logic [2:0] REQ_ACK  = 3'd0;
  localparam logic [2:0] REQ_LOSS = 3'd1;
  localparam logic [2:0] REQ_RTO  = 3'd2;
  localparam logic [2:0] REQ_CONG = 3'd3;
  localparam logic [2:0] REQ_IDLE = 3'd4;

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_BETA    = 3'd1;
  localparam logic [2:0] REG_MSS     = 3'd2;
  localparam logic [2:0] REG_CEIL    = 3'd3;
  localparam logic [2:0] REG_INITWIN = 3'd4;
  localparam logic [2:0] REG_INITTH  = 3'd5;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] smoothed_rtt;
    logic [30:0] acked_bytes;
    logic [31:0] flight_bytes;
    logic [15:0] duplicate_acks;
  } req_t;

  typedef struct packed {
    logic [31:0] window_bytes;
    logic [31:0] threshold_bytes;
    logic [31:0] byte_credit;
    logic [31:0] lowest_rtt;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_cmd_t;

endpackage

FILE: design/vcw_if.sv
// ----------------------------------------------------------------------------
// vcw_stream_if: valid/ready channel
// Carries one payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface vcw_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/vcw_divider.sv
// ----------------------------------------------------------------------------
// vcw_divider: shared 32-bit restoring divider
// One quotient bit per cycle; done flags the result once the last bit is in.
// ----------------------------------------------------------------------------
module vcw_divider (
  input  logic                clk,
  input  logic                rst,
  input  vcw_pkg::div_cmd_t   cmd,
  output logic                done,
  output logic [31:0]         quotient
);
  import vcw_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        rem   <= '0;
        quo   <= cmd.dividend;
        dvs   <= cmd.divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/vegas_congestion_window.sv
// Vegas congestion window: one request in, one result out.
// Idle and unknown requests go straight to S_OUT; slow start, credit, loss and
// timeout use one division, a congestion signal two and a per-RTT reevaluation
// three. One request at a time: a request is taken only in S_IDLE, and a result
// not yet taken holds S_OUT.
// Reset (synchronous, active high) loads register defaults, window 4380,
// threshold all ones, credit zero and an unknown minimum RTT.
// ----------------------------------------------------------------------------
// vegas_congestion_window: TCP Vegas congestion window sequencer
// Sequences the shared divider and a 64-bit adder/compare over each request.
// ----------------------------------------------------------------------------
module vegas_congestion_window (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vcw_stream_if.sink   req,
  vcw_stream_if.source rsp
);
  import vcw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVA  = 4'd1;  // acked/mss or win/mss, flight/mss, (win/2)/mss
  localparam logic [3:0] S_WAITA = 4'd2;
  localparam logic [3:0] S_MULA  = 4'd3;
  localparam logic [3:0] S_DIVB  = 4'd4;  // segs / rtt_floor
  localparam logic [3:0] S_WAITB = 4'd5;
  localparam logic [3:0] S_DIVC  = 4'd6;  // segs / rtt
  localparam logic [3:0] S_WAITC = 4'd7;
  localparam logic [3:0] S_VEGAS = 4'd8;
  localparam logic [3:0] S_APPLY = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_DIVD  = 4'd11; // (flight/2)/mss for a congestion signal
  localparam logic [3:0] S_WAITD = 4'd12;
  localparam logic [3:0] S_MULD  = 4'd13;

  logic [16:0] alpha, beta;
  logic [15:0] mss_reg;
  logic [31:0] ceiling;
  logic [31:0] window, threshold, credit, rtt_floor;
  logic [3:0]  state;
  req_t        cur;
  logic [31:0] mss;
  logic [31:0] rtt, rtt1;
  logic [31:0] segs, expected, qa;
  logic [47:0] prod;
  logic [47:0] mul_out;
  logic [63:0] sum;
  logic        full;
  logic        vegas_due;
  div_cmd_t    cmd;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] diff;

  assign mss  = (mss_reg == 16'd0) ? 32'd1 : {16'd0, mss_reg};
  assign rtt  = {3'd0, cur.smoothed_rtt[31:3]};
  assign rtt1 = (rtt == 32'd0) ? 32'd1 : rtt;
  assign diff = expected - div_q;
  assign mul_out = qa * mss[15:0];
  // window at or above threshold and credit used up: reevaluate against the rates instead of counting down
  assign vegas_due = (window >= threshold) && !((credit != 32'd0) && !credit[31]);

  vcw_divider u_div (.clk(clk), .rst(rst), .cmd(cmd), .done(div_done), .quotient(div_q));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = full;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_DIVA: begin
        cmd.start = 1'b1;
        cmd.divisor = mss;
        unique case (cur.req_type)
          REQ_ACK:  cmd.dividend = vegas_due ? window : {1'b0, cur.acked_bytes};
          REQ_LOSS: cmd.dividend = cur.flight_bytes;
          REQ_RTO, REQ_CONG: cmd.dividend = {1'b0, window[31:1]};
          default:  cmd.dividend = '0;
        endcase
      end
      S_DIVB: begin
        cmd.start = 1'b1;
        cmd.dividend = segs;
        cmd.divisor = (rtt_floor == 32'd0) ? 32'd1 : rtt_floor;
      end
      S_DIVC: begin
        cmd.start = 1'b1;
        cmd.dividend = segs;
        cmd.divisor = rtt1;
      end
      S_DIVD: begin
        cmd.start = 1'b1;
        cmd.dividend = {1'b0, cur.flight_bytes[31:1]};
        cmd.divisor = mss;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 17'd2; beta <= 17'd4; mss_reg <= 16'd1460;
      ceiling <= ALL_ONES;
      window <= 32'd4380; threshold <= ALL_ONES; credit <= '0;
      rtt_floor <= ALL_ONES; state <= S_IDLE; full <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) full <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALPHA:   alpha <= cfg_data[16:0];
          REG_BETA:    beta <= cfg_data[16:0];
          REG_MSS:     mss_reg <= cfg_data[15:0];
          REG_CEIL:    ceiling <= cfg_data;
          REG_INITWIN: window <= cfg_data;
          REG_INITTH:  threshold <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            unique case (req.data.req_type)
              REQ_ACK: begin
                if (rtt_floor > {3'd0, req.data.smoothed_rtt[31:3]})
                  rtt_floor <= (req.data.smoothed_rtt[31:3] == 29'd0) ? 32'd1
                             : {3'd0, req.data.smoothed_rtt[31:3]};
                state <= S_DIVA;
              end
              REQ_LOSS, REQ_RTO, REQ_CONG: state <= S_DIVA;
              REQ_IDLE: begin rtt_floor <= ALL_ONES; state <= S_OUT; end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIVA: state <= S_WAITA;
        S_WAITA: if (div_done) begin
          qa <= div_q;
          segs <= div_q;
          state <= S_MULA;
        end
        S_MULA: begin
          // quotient times mss, for the remainder and round-up in S_APPLY
          prod <= mul_out;
          if (cur.req_type == REQ_ACK && vegas_due) state <= S_DIVB;
          else state <= S_APPLY;
        end
        S_DIVB: state <= S_WAITB;
        S_WAITB: if (div_done) begin expected <= div_q; state <= S_DIVC; end
        S_DIVC: state <= S_WAITC;
        S_WAITC: if (div_done) begin
          if (diff < {15'd0, alpha}) begin
            sum <= {32'd0, window} + {32'd0, mss};
            state <= S_VEGAS;
          end else if (diff > {15'd0, beta}) begin
            sum <= {32'd0, (window > mss) ? window - mss : 32'd0};
            state <= S_VEGAS;
          end else begin
            // hold the window as it is, restart the credit from it
            credit <= window;
            state <= S_OUT;
          end
        end
        S_VEGAS: begin
          window <= (sum > {32'd0, ceiling}) ? ceiling : sum[31:0];
          credit <= (sum > {32'd0, ceiling}) ? ceiling : sum[31:0];
          state <= S_OUT;
        end
        S_APPLY: begin
          // prod = floor(x/mss)*mss; acks, timeouts and congestion round up where a remainder is left
          unique case (cur.req_type)
            REQ_ACK: begin
              logic [32:0] ba;
              logic [63:0] grown;
              ba = {1'b0, prod[31:0]};
              if (prod[31:0] != {1'b0, cur.acked_bytes}) ba = ba + {1'b0, mss};
              if (ba > {mss, 1'b0}) ba = {mss, 1'b0};
              if (window >= threshold) begin
                credit <= credit - ba[31:0];
              end else begin
                grown = {32'd0, window} + {31'd0, ba};
                window <= (grown > {32'd0, ceiling}) ? ceiling : grown[31:0];
              end
            end
            REQ_LOSS: begin
              logic [47:0] m;
              logic [47:0] n;
              logic [31:0] dm;
              n = (qa < 32'd2) ? {15'd0, mss, 1'b0} : prod;
              dm = {16'd0, cur.duplicate_acks} * {16'd0, mss[15:0]};
              m = prod + {16'd0, dm};
              if (({16'd0, qa} + {32'd0, cur.duplicate_acks}) < 48'd2)
                m = {15'd0, mss, 1'b0};
              threshold <= n[31:0];
              window <= (m > {16'd0, ALL_ONES}) ? ALL_ONES : m[31:0];
              credit <= '0; rtt_floor <= ALL_ONES;
            end
            REQ_RTO, REQ_CONG: begin
              logic [47:0] r;
              r = prod;
              if (prod[31:0] != {1'b0, window[31:1]})
                r = prod + {16'd0, mss};
              if (r <= {15'd0, mss, 1'b0}) r = {15'd0, mss, 1'b0};
              threshold <= r[31:0];
              if (cur.req_type == REQ_RTO) window <= mss;
              credit <= '0; rtt_floor <= ALL_ONES;
            end
            default: ;
          endcase
          state <= (cur.req_type == REQ_CONG) ? S_DIVD : S_OUT;
        end
        S_DIVD: state <= S_WAITD;
        S_WAITD: if (div_done) begin
          qa <= div_q;
          state <= S_MULD;
        end
        S_MULD: begin
          window <= mul_out[31:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!full) begin
            full <= 1'b1;
            rsp.data.window_bytes <= window;
            rsp.data.threshold_bytes <= threshold;
            rsp.data.byte_credit <= credit;
            rsp.data.lowest_rtt <= rtt_floor;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Vegas congestion window block
// Drives event requests through a table of directed cases and then random
// traffic, predicts each result in the bench and compares the whole result.
// ----------------------------------------------------------------------------
module tb_top;
  import vcw_pkg::*;

  localparam int CYCLE_LIMIT = 900000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  vcw_stream_if #(.T(req_t)) req ();
  vcw_stream_if #(.T(rsp_t)) rsp ();

  vegas_congestion_window i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  // predictor copy of registers and state
  logic [31:0] p_alpha, p_beta, p_mss, p_ceil, p_iwin, p_ith;
  logic [31:0] p_win, p_th, p_credit, p_floor;

  rsp_t pending_q[$];
  int mismatches;
  int results_seen;
  int cycles;
  bit any_pressure;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t exp_rsp;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] cap_window(logic [63:0] v);
    return (v > {32'd0, p_ceil}) ? p_ceil : v[31:0];
  endfunction

  function automatic logic [63:0] round_segs(logic [63:0] v, logic [63:0] m);
    return ((v + m - 64'd1) / m) * m;
  endfunction

  function automatic logic [31:0] half_threshold(logic [31:0] m);
    logic [63:0] r;
    r = round_segs({33'd0, p_win[31:1]}, {32'd0, m});
    return (r > 64'd2 * m) ? r[31:0] : 2 * m;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_ALPHA:   p_alpha = v & 32'h1FFFF;
      REG_BETA:    p_beta = v & 32'h1FFFF;
      REG_MSS:     p_mss = v & 32'hFFFF;
      REG_CEIL:    p_ceil = v;
      REG_INITWIN: begin p_iwin = v; p_win = v; end
      REG_INITTH:  begin p_ith = v; p_th = v; end
      default: ;
    endcase
  endfunction

  function automatic rsp_t predict_window(req_t r);
    logic [31:0] m, rtt, rtt1, segs, expd, act, diff, fl;
    logic [63:0] ba, npkt, n, mm, w;
    rsp_t o;
    m = (p_mss == 0) ? 32'd1 : p_mss;
    case (r.req_type)
      REQ_ACK: begin
        rtt = r.smoothed_rtt >> 3;
        rtt1 = (rtt == 0) ? 32'd1 : rtt;
        ba = round_segs({33'd0, r.acked_bytes}, {32'd0, m});
        if (ba > 64'd2 * m) ba = 64'd2 * m;
        if (p_floor > rtt) p_floor = rtt1;
        if (p_win >= p_th) begin
          if (p_credit != 0 && !p_credit[31]) begin
            p_credit = p_credit - ba[31:0];
          end else begin
            segs = p_win / m;
            expd = segs / ((p_floor == 0) ? 32'd1 : p_floor);
            act = segs / rtt1;
            diff = expd - act;
            if (diff < p_alpha) p_win = cap_window({32'd0, p_win} + m);
            else if (diff > p_beta) p_win = cap_window((p_win > m) ? p_win - m : 0);
            p_credit = p_win;
          end
        end else begin
          p_win = cap_window({32'd0, p_win} + ba);
        end
      end
      REQ_LOSS: begin
        fl = r.flight_bytes;
        npkt = fl / m;
        n = (npkt < 2) ? 64'd2 : npkt;
        mm = npkt + r.duplicate_acks;
        if (mm < 2) mm = 2;
        p_th = n[31:0] * m;
        w = mm * m;
        p_win = (w > 64'hFFFF_FFFF) ? ALL_ONES : w[31:0];
        p_credit = 0;
        p_floor = ALL_ONES;
      end
      REQ_RTO: begin
        p_th = half_threshold(m);
        p_win = m;
        p_credit = 0;
        p_floor = ALL_ONES;
      end
      REQ_CONG: begin
        p_th = half_threshold(m);
        p_win = ((r.flight_bytes >> 1) / m) * m;
        p_credit = 0;
        p_floor = ALL_ONES;
      end
      REQ_IDLE: p_floor = ALL_ONES;
      default: ;
    endcase
    o.window_bytes = p_win;
    o.threshold_bytes = p_th;
    o.byte_credit = p_credit;
    o.lowest_rtt = p_floor;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, v);
  endtask

  // hold until every result is back, then let the block settle
  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_request(req_t r);
    int gap;
    gap = any_pressure ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_q.push_back(predict_window(r));
  endtask

  function automatic req_t rand_request(bit wellformed);
    req_t r;
    int pick;
    r.smoothed_rtt = $urandom();
    if ($urandom_range(0, 3) != 0) r.smoothed_rtt = $urandom_range(8, 4000);
    r.acked_bytes = 31'($urandom());
    if ($urandom_range(0, 2) != 0) r.acked_bytes = 31'($urandom_range(0, 5000));
    r.flight_bytes = $urandom();
    if ($urandom_range(0, 1) != 0) r.flight_bytes = $urandom_range(0, 200000);
    r.duplicate_acks = 16'($urandom());
    if ($urandom_range(0, 1) != 0) r.duplicate_acks = 16'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (!wellformed) r.req_type = 3'($urandom_range(0, 7));
    else if (pick < 75) r.req_type = REQ_ACK;
    else if (pick < 83) r.req_type = REQ_LOSS;
    else if (pick < 89) r.req_type = REQ_RTO;
    else if (pick < 95) r.req_type = REQ_CONG;
    else r.req_type = REQ_IDLE;
    return r;
  endfunction

  function automatic req_t mk(logic [2:0] t, logic [31:0] s, logic [30:0] a,
                              logic [31:0] f, logic [15:0] d);
    req_t r;
    r.req_type = t;
    r.smoothed_rtt = s;
    r.acked_bytes = a;
    r.flight_bytes = f;
    r.duplicate_acks = d;
    return r;
  endfunction

  function automatic rsp_t mkr(logic [31:0] w, logic [31:0] t, logic [31:0] c,
                               logic [31:0] l);
    rsp_t o;
    o.window_bytes = w;
    o.threshold_bytes = t;
    o.byte_credit = c;
    o.lowest_rtt = l;
    return o;
  endfunction

  // sink side: random stalls and the comparison
  initial begin
    rsp_t got, want;
    int stall;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = any_pressure ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got = rsp.data;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: win %h/%h th %h/%h credit %h/%h rtt %h/%h",
                     want.window_bytes, got.window_bytes, want.threshold_bytes,
                     got.threshold_bytes, want.byte_credit, got.byte_credit,
                     want.lowest_rtt, got.lowest_rtt);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[vegas_congestion_window] ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    rsp_t got_typed;
    int i;
    int phase;
    logic [31:0] v;
    mismatches = 0;
    results_seen = 0;
    any_pressure = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data = 32'd0;
    req.valid = 1'b0;
    req.data = '0;
    p_alpha = 2; p_beta = 4; p_mss = 1460; p_ceil = ALL_ONES;
    p_iwin = 4380; p_ith = ALL_ONES;
    p_win = 4380; p_th = ALL_ONES; p_credit = 0; p_floor = ALL_ONES;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: typed-in results where they follow from reset and the rows before
    rows.push_back('{mk(REQ_IDLE, 0, 0, 0, 0), 1, mkr(4380, ALL_ONES, 0, ALL_ONES)});
    rows.push_back('{mk(3'd5, ALL_ONES, 31'h7FFFFFFF, ALL_ONES, 16'hFFFF), 1,
                     mkr(4380, ALL_ONES, 0, ALL_ONES)});
    rows.push_back('{mk(REQ_ACK, 0, 0, 0, 0), 1, mkr(4380, ALL_ONES, 0, 1)});
    rows.push_back('{mk(REQ_ACK, 800, 1, 0, 0), 1, mkr(5840, ALL_ONES, 0, 1)});
    rows.push_back('{mk(REQ_ACK, ALL_ONES, 31'h7FFFFFFF, 0, 0), 1,
                     mkr(8760, ALL_ONES, 0, 1)});
    rows.push_back('{mk(REQ_RTO, 0, 0, 0, 0), 1, mkr(1460, 4380, 0, ALL_ONES)});
    rows.push_back('{mk(REQ_LOSS, 0, 0, 0, 0), 1, mkr(2920, 2920, 0, ALL_ONES)});
    rows.push_back('{mk(REQ_LOSS, ALL_ONES, 0, ALL_ONES, 16'hFFFF), 0, '0});
    rows.push_back('{mk(REQ_ACK, 400, 1460, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 400, 1460, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 4000, 2000, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_CONG, 0, 0, 32'd300000, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 800, 3000, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 80, 3000, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 8000, 3000, 0, 0), 0, '0});
    rows.push_back('{mk(REQ_CONG, 0, 0, ALL_ONES, 0), 0, '0});
    rows.push_back('{mk(REQ_ACK, 16, 5, 0, 0), 0, '0});
    rows.push_back('{mk(3'd7, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(3'd6, 0, 0, 0, 0), 0, '0});
    for (i = 0; i < rows.size(); i++) begin
      row = rows[i];
      send_request(row.r);
      if (row.typed && pending_q[pending_q.size() - 1] !== row.exp_rsp) begin
        got_typed = pending_q[pending_q.size() - 1];
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predictor %h, table %h", i, got_typed,
                   row.exp_rsp);
      end
    end
    drain_results();

    // phases of register settings, extremes among them
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MSS, 0); write_reg(REG_CEIL, 32'd1);
          write_reg(REG_ALPHA, 32'd1); write_reg(REG_BETA, 32'd1);
          write_reg(REG_INITWIN, 32'd1); write_reg(REG_INITTH, 32'd1);
        end
        1: begin
          write_reg(REG_MSS, 32'hFFFF); write_reg(REG_CEIL, ALL_ONES);
          write_reg(REG_ALPHA, 32'h10000); write_reg(REG_BETA, 32'h10000);
          write_reg(REG_INITWIN, ALL_ONES); write_reg(REG_INITTH, 32'h8000_0000);
        end
        2: begin
          write_reg(REG_MSS, 32'd1460); write_reg(REG_CEIL, 32'd200000);
          write_reg(REG_ALPHA, 32'd2); write_reg(REG_BETA, 32'd4);
          write_reg(REG_INITWIN, 32'd4380); write_reg(REG_INITTH, 32'd20000);
        end
        default: begin
          v = $urandom();
          write_reg(REG_MSS, $urandom_range(0, 3) == 0 ? v : $urandom_range(1, 9000));
          write_reg(REG_CEIL, $urandom_range(0, 2) == 0 ? $urandom()
                                                        : $urandom_range(1, 2000000));
          write_reg(REG_ALPHA, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 6));
          write_reg(REG_BETA, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 12));
          write_reg(REG_INITWIN, $urandom_range(0, 3) == 0 ? $urandom()
                                                           : $urandom_range(1, 60000));
          write_reg(REG_INITTH, $urandom_range(0, 3) == 0 ? $urandom()
                                                          : $urandom_range(1, 300000));
        end
      endcase
      // bursts without idling alternate with random gaps
      for (i = 0; i < 116; i++) begin
        if (i % 40 == 0) any_pressure = (i != 40);
        send_request(rand_request($urandom_range(0, 9) != 0));
      end
      drain_results();
    end
    any_pressure = 0;

    $display("covered %0d results over 9 register settings, incl. zero/max mss", results_seen);
    $display("slow start, per-RTT reevaluation, loss, timeout, congestion, idle");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[vegas_congestion_window] OK");
    end else begin
      $display("%0d mismatches, %0d outstanding", mismatches, pending_q.size());
      $display("[vegas_congestion_window] ERROR");
    end
    $finish;
  end

endmodule
